>>> hw/rtl/set_assoc_cache_tag_controller_assert.svh
// Assertion macros shared by the cache tag controller RTL.
// Needs nothing else; each macro expands to one concurrent assertion.
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SACT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define SACT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sact_pkg.sv
// Package for the set-associative cache tag controller: sizes, codes, row type
// and the replacement LFSR step function. Depends on nothing.
package sact_pkg;

    localparam int MAX_SETS       = 256;
    localparam int MAX_WAYS       = 8;
    localparam int ADDR_BITS      = 32;
    localparam int SET_BITS_LIMIT = 8;
    localparam int TAG_W          = 32;
    localparam int SET_W          = $clog2(MAX_SETS);
    localparam int WAY_W          = $clog2(MAX_WAYS);
    localparam int WAY_CNT_W      = $clog2(MAX_WAYS + 1);
    localparam int CNT_W          = 32;
    localparam int LFSR_W         = 16;
    localparam int DIV_CNT_W      = $clog2(LFSR_W + 1);

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    // Replacement policy codes
    localparam logic [1:0] POL_FIFO   = 2'd0;
    localparam logic [1:0] POL_LRU    = 2'd1;
    localparam logic [1:0] POL_RANDOM = 2'd2;

    // Write mode codes
    localparam logic WM_WRITE_BACK    = 1'b0;
    localparam logic WM_WRITE_THROUGH = 1'b1;

    // Command codes
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Register indexes on the APB port
    localparam logic [2:0] REG_POLICY  = 3'd0;
    localparam logic [2:0] REG_WMODE   = 3'd1;
    localparam logic [2:0] REG_OFFSET  = 3'd2;
    localparam logic [2:0] REG_SETBITS = 3'd3;
    localparam logic [2:0] REG_WAYS    = 3'd4;

    // One set row: a valid bit and a tag per way
    typedef struct packed {
        logic [MAX_WAYS-1:0]            valid;
        logic [MAX_WAYS-1:0][TAG_W-1:0] tags;
    } row_t;

    // Fibonacci step: taps 16,14,13,11, shift right, feedback into the top bit
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[LFSR_W-1:1]};
    endfunction

endpackage

>>> hw/rtl/set_assoc_cache_tag_controller.sv
// Set-associative cache tag controller: set-row memory, lookup and replacement.
// Depends on sact_pkg and set_assoc_cache_tag_controller_assert.svh.
//
// Usage: each input transaction carries a byte address on s_tdata and the
// access kind on s_tuser (0 read, 1 write). The address is split by the
// offset_bits and set_bits registers into a set and a tag; the set's row of
// tags and valid bits is read from a synchronous registered-read memory, compared,
// updated by the replacement policy and written back. One result transaction
// per access leaves on m_tdata with hit, allocate flag, set, tag and the
// running hit and miss counts.
// Sequencing: an access is read from the set-row memory in ST_IDLE, then compared
// and written back in ST_LOOKUP; no new access is taken until the last one has
// written back. A random-policy eviction needs the victim way from a bit-serial
// remainder unit that restarts after reset, after a write of the ways register
// and after each random eviction; an eviction that comes before it is done
// waits for it.
// Reset: all rows read as empty at once (one valid flop per row), counters
// clear, the LFSR takes its seed; no clearing pass is needed.
// Stall: a finished result sits in the output register; the next access is
// still taken, and its write-back and result wait until m_tready takes it.
// Configuration is written over APB by the user only while no access is in flight; the block does not enforce this.
module set_assoc_cache_tag_controller (
    input  logic         aclk,
    input  logic         aresetn,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Input access stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] address
    input  logic         s_tuser,   // [0] command
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] hit, [1] allocated, [9:2] set_index, [41:10] tag_value,
    // [73:42] hits_so_far, [105:74] misses_so_far, [111:106] zero
    output logic [111:0] m_tdata
);
    import sact_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [1:0] policy_reg;
    logic       wmode_reg;
    logic [4:0] offset_reg;
    logic [3:0] setbits_reg;
    logic [3:0] ways_reg;
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Write the addressed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg  <= POL_LRU;
            wmode_reg   <= WM_WRITE_BACK;
            offset_reg  <= 5'd4;
            setbits_reg <= 4'd8;
            ways_reg    <= 4'd8;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_POLICY:  policy_reg  <= pwdata[1:0];
                REG_WMODE:   wmode_reg   <= pwdata[0];
                REG_OFFSET:  offset_reg  <= pwdata[4:0];
                REG_SETBITS: setbits_reg <= pwdata[3:0];
                REG_WAYS:    ways_reg    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (cfg_idx)
            REG_POLICY:  prdata = {30'd0, policy_reg};
            REG_WMODE:   prdata = {31'd0, wmode_reg};
            REG_OFFSET:  prdata = {27'd0, offset_reg};
            REG_SETBITS: prdata = {28'd0, setbits_reg};
            REG_WAYS:    prdata = {28'd0, ways_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // Effective associativity and set bit count
    logic [WAY_CNT_W-1:0] ways_eff;
    logic [3:0]           sb_eff;

    always_comb begin
        if (ways_reg == 4'd0) begin
            ways_eff = WAY_CNT_W'(1);
        end else if (ways_reg > 4'(MAX_WAYS)) begin
            ways_eff = WAY_CNT_W'(MAX_WAYS);
        end else begin
            ways_eff = WAY_CNT_W'(ways_reg);
        end
        sb_eff = (setbits_reg > 4'(SET_BITS_LIMIT)) ? 4'(SET_BITS_LIMIT) : setbits_reg;
    end

    // ---------------------------------------------------------------
    // Address split
    // ---------------------------------------------------------------
    logic [ADDR_BITS-1:0] in_addr;
    logic [5:0]           tag_shift;
    logic [SET_W:0]       set_mask_w;
    logic [SET_W-1:0]     in_set;
    logic [TAG_W-1:0]     in_tag;
    logic [ADDR_BITS-1:0] addr_off;

    assign in_addr    = ADDR_BITS'(s_tdata);
    assign tag_shift  = 6'(offset_reg) + 6'(sb_eff);
    assign addr_off   = in_addr >> offset_reg;
    assign set_mask_w = ((SET_W+1)'(1) << sb_eff) - (SET_W+1)'(1);
    assign in_set     = addr_off[SET_W-1:0] & set_mask_w[SET_W-1:0];
    assign in_tag     = TAG_W'(in_addr >> tag_shift);

    // ---------------------------------------------------------------
    // Control and output registers
    // ---------------------------------------------------------------
    state_t           state_reg;
    logic             s_acc;
    logic             commit;
    logic             out_free;
    logic             need_rand;
    logic             victim_ready;

    logic [SET_W-1:0] cur_set_reg;
    logic [TAG_W-1:0] cur_tag_reg;
    logic             cur_write_reg;

    logic             m_valid_reg;
    logic             m_hit_reg;
    logic             m_alloc_reg;
    logic [SET_W-1:0] m_set_reg;
    logic [TAG_W-1:0] m_tag_reg;
    logic [CNT_W-1:0] hit_cnt_reg;
    logic [CNT_W-1:0] miss_cnt_reg;
    logic [CNT_W-1:0] hit_cnt_next;
    logic [CNT_W-1:0] miss_cnt_next;
    logic [LFSR_W-1:0] lfsr_reg;

    logic [MAX_SETS-1:0] row_init_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, miss_cnt_reg, hit_cnt_reg, m_tag_reg, m_set_reg,
                       m_alloc_reg, m_hit_reg};

    // ---------------------------------------------------------------
    // Set-row memory, one read and one write port, registered read
    // ---------------------------------------------------------------
    row_t row_mem [MAX_SETS];
    row_t rd_row_reg;
    logic row_ok_reg;
    row_t row_next;

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            rd_row_reg <= row_mem[in_set];
        end
        if (commit) begin
            row_mem[cur_set_reg] <= row_next;
        end
    end

    // ---------------------------------------------------------------
    // Lookup and replacement on the row read back
    // ---------------------------------------------------------------
    logic [MAX_WAYS-1:0]            vld;
    logic [MAX_WAYS-1:0]            in_use;
    logic [MAX_WAYS-1:0]            hit_vec;
    logic [MAX_WAYS-1:0]            inv_vec;
    logic [WAY_W-1:0]               hit_idx;
    logic [WAY_W-1:0]               inv_idx;
    logic [WAY_W-1:0]               last_idx;
    logic [WAY_W-1:0]               victim_idx;
    logic                           lk_hit;
    logic                           lk_alloc;
    logic                           has_inv;
    logic [MAX_WAYS-1:0][TAG_W-1:0] nt;
    logic [MAX_WAYS-1:0]            nv;
    logic [DIV_CNT_W-1:0]           div_cnt_reg;
    logic [LFSR_W-1:0]              div_val_reg;
    logic [WAY_CNT_W-1:0]           div_rem_reg;
    logic                           div_busy_reg;
    logic                           div_start_reg;

    assign victim_idx = div_rem_reg[WAY_W-1:0];
    assign last_idx   = WAY_W'(ways_eff - WAY_CNT_W'(1));

    always_comb begin
        logic [TAG_W-1:0] t_swap;
        logic             v_swap;
        t_swap = '0;
        v_swap = 1'b0;
        vld = rd_row_reg.valid & {MAX_WAYS{row_ok_reg}};
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w]  = (WAY_CNT_W'(w) < ways_eff);
            hit_vec[w] = in_use[w] && vld[w] && (rd_row_reg.tags[w] == cur_tag_reg);
            inv_vec[w] = in_use[w] && !vld[w];
        end
        // pick the lowest matching and the lowest empty way
        hit_idx = '0;
        inv_idx = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) hit_idx = WAY_W'(w);
            if (inv_vec[w]) inv_idx = WAY_W'(w);
        end
        lk_hit   = |hit_vec;
        has_inv  = |inv_vec;
        lk_alloc = !lk_hit && !(cur_write_reg == CMD_WRITE && wmode_reg == WM_WRITE_THROUGH);
        need_rand = lk_alloc && !has_inv && (policy_reg != POL_FIFO)
                    && (policy_reg != POL_LRU);

        nt = rd_row_reg.tags;
        nv = vld;
        if (lk_hit) begin
            // bubble valid ways above the hit way one place down
            if (policy_reg == POL_LRU) begin
                for (int j = 1; j < MAX_WAYS; j++) begin
                    if ((WAY_W'(j) > hit_idx) && in_use[j] && nv[j]) begin
                        t_swap  = nt[j];
                        v_swap  = nv[j];
                        nt[j]   = nt[j-1];
                        nv[j]   = nv[j-1];
                        nt[j-1] = t_swap;
                        nv[j-1] = v_swap;
                    end
                end
            end
        end else if (lk_alloc) begin
            if (has_inv) begin
                nt[inv_idx] = cur_tag_reg;
                nv[inv_idx] = 1'b1;
            end else if (!need_rand) begin
                // drop the front way, shift the rest forward, append at the back
                for (int j = 0; j < MAX_WAYS - 1; j++) begin
                    if (in_use[j+1]) begin
                        nt[j] = rd_row_reg.tags[j+1];
                        nv[j] = vld[j+1];
                    end
                end
                nt[last_idx] = cur_tag_reg;
                nv[last_idx] = 1'b1;
            end else begin
                nt[victim_idx] = cur_tag_reg;
            end
        end
        row_next.tags  = nt;
        row_next.valid = nv;
    end

    assign commit        = (state_reg == ST_LOOKUP) && out_free && (!need_rand || victim_ready);
    assign hit_cnt_next  = lk_hit ? hit_cnt_reg + CNT_W'(1) : hit_cnt_reg;
    assign miss_cnt_next = lk_hit ? miss_cnt_reg : miss_cnt_reg + CNT_W'(1);

    // Sequence the access, hold the result until taken, update counters and LFSR
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            lfsr_reg     <= LFSR_SEED;
            row_init_reg <= '0;
            row_ok_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && !commit) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        cur_set_reg   <= in_set;
                        cur_tag_reg   <= in_tag;
                        cur_write_reg <= s_tuser;
                        row_ok_reg    <= row_init_reg[in_set];
                        state_reg     <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP: begin
                    if (commit) begin
                        m_valid_reg               <= 1'b1;
                        m_hit_reg                 <= lk_hit;
                        m_alloc_reg               <= lk_alloc;
                        m_set_reg                 <= cur_set_reg;
                        m_tag_reg                 <= cur_tag_reg;
                        hit_cnt_reg               <= hit_cnt_next;
                        miss_cnt_reg              <= miss_cnt_next;
                        row_init_reg[cur_set_reg] <= 1'b1;
                        if (need_rand) begin
                            lfsr_reg <= lfsr_next(lfsr_reg);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Victim way: next LFSR value modulo the ways, one bit per cycle
    // ---------------------------------------------------------------
    logic [WAY_CNT_W-1:0] div_trial;

    assign victim_ready = !div_start_reg && !div_busy_reg;
    assign div_trial    = {div_rem_reg[WAY_CNT_W-2:0], div_val_reg[LFSR_W-1]};

    // Restart after reset, a ways write or an LFSR advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_start_reg <= 1'b1;
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            div_rem_reg   <= '0;
        end else begin
            div_start_reg <= (cfg_wr && cfg_idx == REG_WAYS) || (commit && need_rand);
            if (div_start_reg) begin
                div_val_reg  <= lfsr_next(lfsr_reg);
                div_rem_reg  <= '0;
                div_cnt_reg  <= DIV_CNT_W'(LFSR_W);
                div_busy_reg <= 1'b1;
            end else if (div_busy_reg) begin
                div_rem_reg  <= (div_trial >= ways_eff) ? div_trial - ways_eff : div_trial;
                div_val_reg  <= {div_val_reg[LFSR_W-2:0], 1'b0};
                div_cnt_reg  <= div_cnt_reg - DIV_CNT_W'(1);
                div_busy_reg <= (div_cnt_reg != DIV_CNT_W'(1));
            end
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `include "set_assoc_cache_tag_controller_assert.svh"

    `SACT_ASSERT_NEXT(a_commit_shows_result, aclk, aresetn, commit, m_valid_reg, "result lost after commit")
    `SACT_ASSERT_NOW(a_hit_not_alloc, aclk, aresetn, m_valid_reg, !(m_hit_reg && m_alloc_reg), "hit and allocate together")
    `SACT_ASSERT_NEXT(a_one_count_per_access, aclk, aresetn, commit, (hit_cnt_reg + miss_cnt_reg) == CNT_W'($past(hit_cnt_reg + miss_cnt_reg) + CNT_W'(1)), "counters moved by other than one")
    `SACT_ASSERT_NOW(a_victim_in_range, aclk, aresetn, victim_ready, div_rem_reg < ways_eff, "victim way beyond ways in use")

endmodule

>>> bench/tb_set_assoc_cache_tag_controller.sv
// Testbench for the set-associative cache tag controller: drives accesses and APB writes,
// predicts every lookup result from its own tag store and checks the result stream.
// Depends on sact_pkg and the set_assoc_cache_tag_controller RTL.
module tb_set_assoc_cache_tag_controller;
    import sact_pkg::*;

    localparam int          CYCLE_LIMIT    = 500000;
    localparam int          SETTLE_CYCLES  = 24;     // long enough for the victim divider to finish
    localparam int          LONG_HOLD      = 300;
    localparam logic [1:0]  POL_RANDOM_ALT = 2'd3;   // undefined code, behaves as random

    typedef struct {
        logic        hit;
        logic        allocated;
        logic [7:0]  set_index;
        logic [31:0] tag_value;
        logic [31:0] hits_so_far;
        logic [31:0] misses_so_far;
    } lookup_result_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         psel, penable, pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid, s_tready;
    logic [31:0]  s_tdata;   // [31:0] address
    logic         s_tuser;   // [0] command
    logic         m_tvalid, m_tready;
    // [0] hit, [1] allocated, [9:2] set_index, [41:10] tag_value,
    // [73:42] hits_so_far, [105:74] misses_so_far, [111:106] zero
    logic [111:0] m_tdata;

    // Shadow of the tag store, counters and registers
    logic [31:0]  way_tag_mem   [MAX_SETS][MAX_WAYS];
    logic         way_valid_mem [MAX_SETS][MAX_WAYS];
    logic [15:0]  repl_lfsr       = LFSR_SEED;
    logic [31:0]  hit_count       = '0;
    logic [31:0]  miss_count      = '0;
    logic [1:0]   cfg_policy      = POL_LRU;
    logic         cfg_write_mode  = WM_WRITE_BACK;
    logic [4:0]   cfg_offset_bits = 5'd4;
    logic [3:0]   cfg_set_bits    = 4'd8;
    logic [3:0]   cfg_ways        = 4'd8;

    lookup_result_t expected_lookups[$];
    int           error_count   = 0;
    int           cycle_count   = 0;
    int           hold_request  = 0;
    bit           send_idle_en  = 1'b1;
    bit           recv_idle_en  = 1'b1;

    set_assoc_cache_tag_controller dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TIMEOUT at %0t after %0d cycles", $time, cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Look up one access in the shadow store, update it and return the expected result
    function automatic lookup_result_t predict_lookup(input logic cmd, input logic [31:0] addr);
        lookup_result_t res;
        logic [63:0]    addr64;
        logic [31:0]    tag, held_tag;
        logic           held_valid;
        int unsigned    sb, ways, set_no, hit_way, fill_way;
        bit             hit;
        sb   = (cfg_set_bits > SET_BITS_LIMIT) ? SET_BITS_LIMIT : cfg_set_bits;
        ways = (cfg_ways == 0) ? 1 : cfg_ways;
        if (ways > MAX_WAYS) ways = MAX_WAYS;
        addr64 = {32'd0, addr};
        set_no = 32'((addr64 >> cfg_offset_bits) & ((64'd1 << sb) - 64'd1)) % MAX_SETS;
        tag    = 32'(addr64 >> (cfg_offset_bits + sb));
        hit     = 1'b0;
        hit_way = 0;
        for (int w = 0; w < ways; w++) begin
            if (!hit && way_valid_mem[set_no][w] && way_tag_mem[set_no][w] == tag) begin
                hit     = 1'b1;
                hit_way = w;
            end
        end
        res.allocated = 1'b0;
        if (hit) begin
            hit_count++;
            // Bubble the hit way toward the back of the valid run
            if (cfg_policy == POL_LRU) begin
                for (int j = hit_way + 1; j < ways; j++) begin
                    if (way_valid_mem[set_no][j]) begin
                        held_tag                    = way_tag_mem[set_no][j];
                        held_valid                  = way_valid_mem[set_no][j];
                        way_tag_mem[set_no][j]      = way_tag_mem[set_no][j-1];
                        way_valid_mem[set_no][j]    = way_valid_mem[set_no][j-1];
                        way_tag_mem[set_no][j-1]    = held_tag;
                        way_valid_mem[set_no][j-1]  = held_valid;
                    end
                end
            end
        end else begin
            miss_count++;
            if (!(cmd == CMD_WRITE && cfg_write_mode == WM_WRITE_THROUGH)) begin
                res.allocated = 1'b1;
                fill_way = ways;
                for (int w = int'(ways) - 1; w >= 0; w--)
                    if (!way_valid_mem[set_no][w]) fill_way = w;
                if (fill_way < ways) begin
                    way_valid_mem[set_no][fill_way] = 1'b1;
                    way_tag_mem[set_no][fill_way]   = tag;
                end else if (cfg_policy == POL_FIFO || cfg_policy == POL_LRU) begin
                    // Drop the front way, append at the back
                    for (int j = 1; j < ways; j++) begin
                        way_tag_mem[set_no][j-1]   = way_tag_mem[set_no][j];
                        way_valid_mem[set_no][j-1] = way_valid_mem[set_no][j];
                    end
                    way_tag_mem[set_no][ways-1]   = tag;
                    way_valid_mem[set_no][ways-1] = 1'b1;
                end else begin
                    repl_lfsr = {repl_lfsr[0] ^ repl_lfsr[2] ^ repl_lfsr[3] ^ repl_lfsr[5],
                                 repl_lfsr[15:1]};
                    way_tag_mem[set_no][repl_lfsr % ways] = tag;
                end
            end
        end
        res.hit           = hit;
        res.set_index     = set_no[7:0];
        res.tag_value     = tag;
        res.hits_so_far   = hit_count;
        res.misses_so_far = miss_count;
        return res;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Check each result transaction against the oldest expectation
    always @(posedge aclk) begin
        lookup_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_lookups.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
                error_count++;
            end else begin
                want = expected_lookups.pop_front();
                compare_field("hit",           32'(want.hit),       32'(m_tdata[0]));
                compare_field("allocated",     32'(want.allocated), 32'(m_tdata[1]));
                compare_field("set_index",     32'(want.set_index), 32'(m_tdata[9:2]));
                compare_field("tag_value",     want.tag_value,      m_tdata[41:10]);
                compare_field("hits_so_far",   want.hits_so_far,    m_tdata[73:42]);
                compare_field("misses_so_far", want.misses_so_far,  m_tdata[105:74]);
            end
        end
    end

    // Result side: random stalls plus an on-demand long hold, counted here
    initial begin
        int gap;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request != 0) begin
                gap          = hold_request;
                hold_request = 0;
            end else begin
                gap = recv_idle_en ? idle_gap() : 0;
            end
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    // Offer one access; enter and leave at a falling edge
    task automatic send_access(input logic cmd, input logic [31:0] addr);
        int gap;
        s_tdata  = addr;
        s_tuser  = cmd;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_lookups.insert(expected_lookups.size(), predict_lookup(cmd, addr));
        @(negedge aclk);
        gap = send_idle_en ? idle_gap() : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_results_drained();
        s_tvalid = 1'b0;
        while (expected_lookups.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_POLICY:  cfg_policy      = value[1:0];
            REG_WMODE:   cfg_write_mode  = value[0];
            REG_OFFSET:  cfg_offset_bits = value[4:0];
            REG_SETBITS: cfg_set_bits    = value[3:0];
            REG_WAYS:    cfg_ways        = value[3:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Reconfigure only once the block is idle and the victim divider has settled
    task automatic configure_cache(input logic [1:0] policy, input logic wmode,
                                   input int offset, input int sbits, input int ways);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_register(REG_POLICY,  32'(policy));
        write_register(REG_WMODE,   32'(wmode));
        write_register(REG_OFFSET,  32'(offset));
        write_register(REG_SETBITS, 32'(sbits));
        write_register(REG_WAYS,    32'(ways));
    endtask

    // Reset values: LRU, write-back, 16-byte blocks, 256 sets, 8 ways
    task automatic test_reset_defaults();
        send_access(CMD_READ,  32'h0000_0000);
        send_access(CMD_READ,  32'h0000_000F);
        send_access(CMD_WRITE, 32'hFFFF_FFFF);
        send_access(CMD_READ,  32'h8000_0000);
    endtask

    // LRU: a hit moves the way back, so the next miss drops a different tag
    task automatic test_lru_order();
        configure_cache(POL_LRU, WM_WRITE_BACK, 0, 0, 3);
        send_access(CMD_READ,  32'h10);
        send_access(CMD_WRITE, 32'h20);
        send_access(CMD_READ,  32'h30);
        send_access(CMD_READ,  32'h10);
        send_access(CMD_READ,  32'h40);
        send_access(CMD_READ,  32'h20);
        send_access(CMD_READ,  32'h10);
    endtask

    // FIFO: a hit leaves the order alone
    task automatic test_fifo_order();
        configure_cache(POL_FIFO, WM_WRITE_BACK, 2, 1, 2);
        send_access(CMD_READ, 32'h0000_0100);
        send_access(CMD_READ, 32'h0000_0200);
        send_access(CMD_READ, 32'h0000_0100);
        send_access(CMD_READ, 32'h0000_0300);
        send_access(CMD_READ, 32'h0000_0104);
    endtask

    // Random victims, then the undefined policy code acting as random
    task automatic test_random_victims();
        configure_cache(POL_RANDOM, WM_WRITE_BACK, 0, 0, 3);
        for (int k = 1; k <= 5; k++) send_access(CMD_READ, 32'(k));
        send_access(CMD_READ, 32'd1);
        configure_cache(POL_RANDOM_ALT, WM_WRITE_BACK, 0, 0, 3);
        send_access(CMD_READ, 32'd9);
        send_access(CMD_READ, 32'd9);
    endtask

    // Write-through: write misses do not allocate
    task automatic test_write_through();
        configure_cache(POL_LRU, WM_WRITE_THROUGH, 4, 2, 2);
        send_access(CMD_WRITE, 32'h0000_1230);
        send_access(CMD_READ,  32'h0000_1230);
        send_access(CMD_WRITE, 32'h0000_1234);
        send_access(CMD_WRITE, 32'h0000_5670);
    endtask

    // Out-of-range ways and set bits, widest offset
    task automatic test_config_extremes();
        configure_cache(POL_FIFO, WM_WRITE_BACK, 31, 15, 0);
        send_access(CMD_READ, 32'hFFFF_FFFF);
        send_access(CMD_READ, 32'h0000_0000);
        configure_cache(POL_LRU, WM_WRITE_BACK, 16, 8, 15);
        send_access(CMD_READ, 32'hABCD_1234);
        send_access(CMD_READ, 32'h5432_1234);
    endtask

    // Hold the result side long enough that the block stalls its input
    task automatic test_backpressure();
        configure_cache(POL_LRU, WM_WRITE_BACK, 4, 3, 4);
        send_idle_en = 1'b0;
        hold_request = LONG_HOLD;
        for (int k = 0; k < 30; k++)
            send_access(1'($urandom_range(0, 1)), 32'($urandom_range(0, 15)) << 4);
        wait_results_drained();
        send_idle_en = 1'b1;
    endtask

    // Random accesses over a small pool of sets and tags so that sets fill and evict
    task automatic run_traffic_phase(input int num_items);
        logic [31:0] pool_sets[3];
        logic [31:0] pool_tags[$];
        logic [63:0] addr64;
        int          sb, ways, off;
        sb   = (cfg_set_bits > SET_BITS_LIMIT) ? SET_BITS_LIMIT : cfg_set_bits;
        ways = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS) ? MAX_WAYS : cfg_ways);
        off  = cfg_offset_bits;
        foreach (pool_sets[k]) pool_sets[k] = $urandom_range(0, 255);
        for (int k = 0; k < ways + 2; k++) pool_tags.insert(pool_tags.size(), $urandom);
        for (int n = 0; n < num_items; n++) begin
            if ($urandom_range(0, 99) < 15) begin
                addr64 = {32'd0, $urandom};
            end else begin
                addr64 = ({32'd0, pool_tags[$urandom_range(0, ways + 1)]} << (off + sb))
                       | ((64'(pool_sets[$urandom_range(0, 2)]) & ((64'd1 << sb) - 1)) << off)
                       | (64'($urandom) & ((64'd1 << off) - 1));
            end
            send_access(1'($urandom_range(0, 1)), addr64[31:0]);
            // On a coin toss, pause the sender mid-phase until everything is back
            if (n == num_items / 2 && $urandom_range(0, 1)) wait_results_drained();
        end
    endtask

    task automatic test_random_traffic();
        configure_cache(POL_FIFO, WM_WRITE_BACK, 0, 0, 1);
        run_traffic_phase(60);
        configure_cache(POL_RANDOM_ALT, WM_WRITE_THROUGH, 31, 15, 15);
        run_traffic_phase(40);
        for (int p = 0; p < 6; p++) begin
            configure_cache(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                        : $urandom_range(0, 12),
                            $urandom_range(0, 15), $urandom_range(0, 15));
            // Every third phase runs without idling on either side
            send_idle_en = (p % 3 != 1);
            recv_idle_en = (p % 3 != 1);
            run_traffic_phase(65);
        end
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    initial begin
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_READ;
        foreach (way_valid_mem[s, w]) way_valid_mem[s][w] = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_lru_order();
        test_fifo_order();
        test_random_victims();
        test_write_through();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();

        // Let stray results show up before the verdict
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/sact_pkg.sv
hw/rtl/set_assoc_cache_tag_controller.sv
bench/tb_set_assoc_cache_tag_controller.sv
